FILE: rtl/core/dfe_pkg.sv
// ----------------------------------------------------------------------------
// dfe_pkg
// Shared widths, register indexes, reset values and control types of the
// delimiter frame extractor.
// ----------------------------------------------------------------------------
`default_nettype none

package dfe_pkg;

    localparam int DFE_FRAME_DEPTH = 64;
    localparam int DFE_DELIM_MAX   = 4;

    localparam int DATA_W     = 8;
    localparam int SIZE_W     = 7;
    localparam int LEN_CFG_W  = 3;
    localparam int PAT_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_START_LEN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_PAT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_END_LEN   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_END_PAT   = 2'd3;

    localparam logic [LEN_CFG_W-1:0] START_LEN_RST = 3'd1;
    localparam logic [PAT_W-1:0]     START_PAT_RST = 32'h0000_0024;
    localparam logic [LEN_CFG_W-1:0] END_LEN_RST   = 3'd2;
    localparam logic [PAT_W-1:0]     END_PAT_RST   = 32'h0000_0A0D;

    typedef struct packed {
        logic take;
        logic rd_en;
        logic send;
    } dfe_cmd_t;

    typedef struct packed {
        logic frame_done;
        logic last_word;
    } dfe_status_t;

endpackage

`default_nettype wire

FILE: rtl/core/dfe_ifs.sv
// ----------------------------------------------------------------------------
// dfe channel interfaces
// Valid/ready channels for input bytes, frame output words and config writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface dfe_byte_if
    import dfe_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface dfe_frame_if
    import dfe_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] frame_byte;
    logic              frame_end;
    logic [SIZE_W-1:0] frame_size;

    modport source (output valid, output frame_byte, output frame_end,
                    output frame_size, input ready);
    modport sink   (input valid, input frame_byte, input frame_end,
                    input frame_size, output ready);
endinterface

interface dfe_cfg_if
    import dfe_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/dfe_ctrl.sv
// ----------------------------------------------------------------------------
// dfe_ctrl
// Sequencer: collects bytes, then reads a finished frame out of the store.
// ----------------------------------------------------------------------------
`default_nettype none

module dfe_ctrl
    import dfe_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  wire logic        out_ready,
    input  wire dfe_status_t status,
    output dfe_cmd_t         cmd
);

    typedef enum logic [1:0] {
        ST_COLLECT,
        ST_LOAD,
        ST_SEND
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_ready_reg;
    logic   out_valid_reg;

    assign in_ready  = in_ready_reg;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd.take   = in_valid && in_ready_reg;
        cmd.send   = out_valid_reg && out_ready;
        cmd.rd_en  = 1'b0;
        state_next = state_reg;
        case (state_reg)
            ST_COLLECT:
            begin
                if (cmd.take && status.frame_done)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = ST_SEND;
            end
            ST_SEND:
            begin
                if (cmd.send)
                begin
                    if (status.last_word)
                    begin
                        state_next = ST_COLLECT;
                    end
                    else
                    begin
                        cmd.rd_en = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_COLLECT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_COLLECT;
            in_ready_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_ready_reg  <= (state_next == ST_COLLECT);
            out_valid_reg <= (state_next == ST_SEND);
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/dfe_datapath.sv
// ----------------------------------------------------------------------------
// dfe_datapath
// Config registers, delimiter match history, circular frame store and
// readout pointers.
// ----------------------------------------------------------------------------
`default_nettype none

module dfe_datapath
    import dfe_pkg::*;
#(
    parameter int FRAME_DEPTH = DFE_FRAME_DEPTH,
    parameter int DELIM_MAX   = DFE_DELIM_MAX
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    dfe_cfg_if.sink                cfg,
    input  wire logic [DATA_W-1:0] data_byte,
    input  wire dfe_cmd_t          cmd,
    output dfe_status_t            status,
    output logic [DATA_W-1:0]      frame_byte,
    output logic                   frame_end,
    output logic [SIZE_W-1:0]      frame_size
);

    localparam int AW = $clog2(FRAME_DEPTH);
    localparam int FW = $clog2(FRAME_DEPTH + 1);
    localparam int LW = $clog2(DELIM_MAX + 1);
    localparam int CW = (FW > LW + 1) ? FW : LW + 1;
    localparam int RW = 8 * DELIM_MAX;
    localparam int PB = (DELIM_MAX > 4) ? DELIM_MAX : 4;

    logic [LEN_CFG_W-1:0] start_len_reg;
    logic [PAT_W-1:0]     start_pat_reg;
    logic [LEN_CFG_W-1:0] end_len_reg;
    logic [PAT_W-1:0]     end_pat_reg;

    logic [RW-1:0] recent_reg;
    logic [RW-1:0] recent_next;
    logic [LW-1:0] rvalid_reg;
    logic [LW-1:0] rvalid_next;
    logic          in_frame_reg;
    logic          in_frame_next;
    logic [FW-1:0] fill_reg;
    logic [FW-1:0] fill_next;
    logic [AW-1:0] wp_reg;
    logic [FW-1:0] remain_reg;

    logic [DATA_W-1:0] mem [FRAME_DEPTH];
    logic [AW-1:0]     rd_addr_reg;
    logic [DATA_W-1:0] rd_data_reg;
    logic [FW-1:0]     size_reg;

    logic [RW-1:0]   rec_shift;
    logic [LW-1:0]   rv_inc;
    logic [LW-1:0]   sl;
    logic [LW-1:0]   el;
    logic [FW-1:0]   fill_inc;
    logic [AW-1:0]   base;
    logic            room;
    logic            start_hit;
    logic            end_hit;
    logic            restart;

    function automatic logic [LW-1:0] eff_len(input logic [LEN_CFG_W-1:0] len);
        logic [LW-1:0] r;
        if (len == '0)
        begin
            r = LW'(1);
        end
        else if (int'(len) > DELIM_MAX)
        begin
            r = LW'(DELIM_MAX);
        end
        else
        begin
            r = LW'(len);
        end
        return r;
    endfunction

    function automatic logic tail_match(input logic [RW-1:0] rec,
                                        input logic [LW-1:0] rv,
                                        input logic [PAT_W-1:0] pattern,
                                        input logic [LW-1:0] len);
        logic [8*PB-1:0] pat;
        logic            ok;
        pat = (8*PB)'(pattern);
        ok  = 1'b0;
        for (int l = 1; l <= DELIM_MAX; l++)
        begin
            if (len == LW'(l))
            begin
                ok = 1'b1;
                for (int j = 0; j < l; j++)
                begin
                    if (rec[8*j +: 8] != pat[8*(l-1-j) +: 8])
                    begin
                        ok = 1'b0;
                    end
                end
            end
        end
        return ok && (rv >= len);
    endfunction

    assign cfg.ready = 1'b1;

    always_comb
    begin
        sl        = eff_len(start_len_reg);
        el        = eff_len(end_len_reg);
        rec_shift = (recent_reg << 8) | RW'(data_byte);
        rv_inc    = (int'(rvalid_reg) < DELIM_MAX) ? rvalid_reg + LW'(1) : rvalid_reg;
        fill_inc  = fill_reg + FW'(1);
        room      = in_frame_reg && (fill_reg < FW'(FRAME_DEPTH));
        start_hit = tail_match(rec_shift, rv_inc, start_pat_reg, sl);
        end_hit   = room && (CW'(fill_inc) >= CW'(sl) + CW'(el))
                    && tail_match(rec_shift, rv_inc, end_pat_reg, el);
        restart   = room && !end_hit && (CW'(fill_inc) >= CW'(sl) + CW'(sl))
                    && start_hit;

        if (FW'(wp_reg) >= fill_reg)
        begin
            base = AW'(FW'(wp_reg) - fill_reg);
        end
        else
        begin
            base = AW'(FW'(wp_reg) + FW'(FRAME_DEPTH) - fill_reg);
        end

        recent_next   = rec_shift;
        rvalid_next   = rv_inc;
        in_frame_next = 1'b0;
        fill_next     = '0;
        if (end_hit)
        begin
            recent_next = '0;
            rvalid_next = '0;
        end
        else if (room)
        begin
            in_frame_next = 1'b1;
            fill_next     = restart ? FW'(sl) : fill_inc;
        end
        else if (start_hit)
        begin
            in_frame_next = 1'b1;
            fill_next     = FW'(sl);
        end
    end

    assign status.frame_done = end_hit;
    assign status.last_word  = (remain_reg == FW'(1));

    assign frame_byte = rd_data_reg;
    assign frame_end  = status.last_word;
    assign frame_size = SIZE_W'(size_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_len_reg <= START_LEN_RST;
            start_pat_reg <= START_PAT_RST;
            end_len_reg   <= END_LEN_RST;
            end_pat_reg   <= END_PAT_RST;
            recent_reg    <= '0;
            rvalid_reg    <= '0;
            in_frame_reg  <= 1'b0;
            fill_reg      <= '0;
            wp_reg        <= '0;
            remain_reg    <= '0;
        end
        else
        begin
            if (cfg.valid)
            begin
                case (cfg.index)
                    REG_START_LEN: start_len_reg <= LEN_CFG_W'(cfg.data);
                    REG_START_PAT: start_pat_reg <= PAT_W'(cfg.data);
                    REG_END_LEN:   end_len_reg   <= LEN_CFG_W'(cfg.data);
                    REG_END_PAT:   end_pat_reg   <= PAT_W'(cfg.data);
                    default:       ;
                endcase
            end
            if (cmd.take)
            begin
                recent_reg   <= recent_next;
                rvalid_reg   <= rvalid_next;
                in_frame_reg <= in_frame_next;
                fill_reg     <= fill_next;
                wp_reg       <= (wp_reg == AW'(FRAME_DEPTH - 1)) ? '0 : wp_reg + AW'(1);
                if (end_hit)
                begin
                    remain_reg <= fill_inc;
                end
            end
            else if (cmd.send)
            begin
                remain_reg <= remain_reg - FW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            mem[wp_reg] <= data_byte;
            if (end_hit)
            begin
                rd_addr_reg <= base;
                size_reg    <= fill_inc;
            end
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_addr_reg];
            rd_addr_reg <= (rd_addr_reg == AW'(FRAME_DEPTH - 1)) ? '0
                                                                   : rd_addr_reg + AW'(1);
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/delimiter_frame_extractor_core.sv
// ----------------------------------------------------------------------------
// delimiter_frame_extractor_core
// Start/end delimiter framer: hunts for a start delimiter, buffers the frame
// in a circular byte store and emits it once the end delimiter completes.
// ----------------------------------------------------------------------------
// Bytes are taken one per cycle while collecting.
// A completed frame goes through ST_LOAD, reading its first word, to ST_SEND
// and streams at one word per cycle unless frame_out.ready is low, bounded
// by the single store read port; input waits for the last word to be sent.
// rst_n (async, low) clears control state, the match history and restores
// the register defaults; the frame store is not cleared.
`default_nettype none

module delimiter_frame_extractor_core
    import dfe_pkg::*;
#(
    parameter int FRAME_DEPTH = DFE_FRAME_DEPTH,
    parameter int DELIM_MAX   = DFE_DELIM_MAX
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    dfe_cfg_if.sink     cfg,
    dfe_byte_if.sink    byte_in,
    dfe_frame_if.source frame_out
);

    dfe_cmd_t    cmd;
    dfe_status_t status;

    dfe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (byte_in.valid),
        .in_ready  (byte_in.ready),
        .out_valid (frame_out.valid),
        .out_ready (frame_out.ready),
        .status    (status),
        .cmd       (cmd)
    );

    dfe_datapath #(
        .FRAME_DEPTH (FRAME_DEPTH),
        .DELIM_MAX   (DELIM_MAX)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .data_byte  (byte_in.data_byte),
        .cmd        (cmd),
        .status     (status),
        .frame_byte (frame_out.frame_byte),
        .frame_end  (frame_out.frame_end),
        .frame_size (frame_out.frame_size)
    );

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(byte_in.ready && frame_out.valid))
        else $error("input taken during frame readout");

    a_done_reads: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.take && status.frame_done) |=> (cmd.rd_en && !frame_out.valid))
        else $error("completed frame did not start readout");

    a_end_resumes: assert property (@(posedge clk) disable iff (!rst_n)
        (frame_out.valid && frame_out.ready && frame_out.frame_end) |=> byte_in.ready)
        else $error("collection did not resume after last word");

    a_min_size: assert property (@(posedge clk) disable iff (!rst_n)
        frame_out.valid |-> (frame_out.frame_size >= SIZE_W'(2)))
        else $error("frame shorter than two words");

endmodule

`default_nettype wire
